@@ hw/rtl/acl_tok_pkg.sv @@
// Package for the access-control configuration text tokenizer.
// Holds character codes, result kind codes, the classified-byte struct and keyword tables.
// No dependencies.
package acl_tok_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UC_R  = 8'h52;
    localparam logic [7:0] CH_UC_W  = 8'h57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_O  = 8'h6F;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    typedef enum logic [3:0] {
        K_MNAME   = 4'd0,
        K_MVALUE  = 4'd1,
        K_MEND    = 4'd2,
        K_REPO    = 4'd3,
        K_REPOEND = 4'd4,
        K_USER    = 4'd5,
        K_RULEEND = 4'd6,
        K_INC     = 4'd7,
        K_INCEND  = 4'd8,
        K_SYNTAX  = 4'd9,
        K_LENGTH  = 4'd10
    } t_kind;

    // One byte after classification by the front.
    typedef struct packed {
        logic [7:0] ch;
        logic       first;     // restart parser before this byte
        logic       parse_en;  // byte lies outside a comment
        logic       is_ws;
        logic       is_nl;
        logic       is_eq;
        logic       is_at;
        logic       is_quote;
    } t_cls;

    // Letters of "include" after the leading i, position 1..6.
    function automatic logic [7:0] f_include_char(input logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd1:    r = 8'h6E;
            3'd2:    r = 8'h63;
            3'd3:    r = 8'h6C;
            3'd4:    r = 8'h75;
            3'd5:    r = 8'h64;
            3'd6:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Letters of "config" after the leading c, position 1..5.
    function automatic logic [7:0] f_config_char(input logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd1:    r = 8'h6F;
            3'd2:    r = 8'h6E;
            3'd3:    r = 8'h66;
            3'd4:    r = 8'h69;
            3'd5:    r = 8'h67;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/acl_tok_front.sv @@
// Front stage of the tokenizer: accepts bytes, tracks comments, classifies characters.
// Depends on acl_tok_pkg.
module acl_tok_front
    import acl_tok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_first_of_file,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cls       o_item
);

    logic r_in_comment;
    logic n_in_comment;
    logic w_is_nl;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign w_is_nl    = (i_text_byte == CH_NL);

    // Comment runs from '#' up to, not including, the newline.
    always_comb begin
        n_in_comment = i_first_of_file ? 1'b0 : r_in_comment;
        if (!n_in_comment && i_text_byte == CH_HASH) begin
            n_in_comment = 1'b1;
        end
        if (n_in_comment && w_is_nl) begin
            n_in_comment = 1'b0;
        end
    end

    always_comb begin
        o_item.ch       = i_text_byte;
        o_item.first    = i_first_of_file;
        o_item.parse_en = !n_in_comment;
        o_item.is_ws    = (i_text_byte == CH_SPACE) || (i_text_byte == CH_TAB);
        o_item.is_nl    = w_is_nl;
        o_item.is_eq    = (i_text_byte == CH_EQ);
        o_item.is_at    = (i_text_byte == CH_AT);
        o_item.is_quote = (i_text_byte == CH_QUOTE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
        end else if (o_push) begin
            r_in_comment <= n_in_comment;
        end
    end

endmodule

@@ hw/rtl/acl_tok_queue.sv @@
// Short register queue of classified bytes between front and back.
// Depends on acl_tok_pkg.
module acl_tok_queue
    import acl_tok_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_item,
    output logic o_full,
    output logic o_valid,
    output t_cls o_item,
    input  logic i_pop
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_cls            r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == (AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/acl_tok_back.sv @@
// Back stage of the tokenizer: parse state machine, line counter and result register.
// Depends on acl_tok_pkg.
module acl_tok_back
    import acl_tok_pkg::*;
#(
    parameter int NAME_MAX_LEN  = 31,
    parameter int VALUE_MAX_LEN = 1023,
    parameter int LINE_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_cls        i_item,
    output logic        o_item_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_line_number
);

    localparam int MAX_LEN = (NAME_MAX_LEN > VALUE_MAX_LEN) ? NAME_MAX_LEN : VALUE_MAX_LEN;
    localparam int POS_RAW = $clog2(MAX_LEN + 1);
    // Keyword matching counts up to six.
    localparam int POS_W   = (POS_RAW < 3) ? 3 : POS_RAW;
    localparam logic [POS_W-1:0] NAME_LIM  = POS_W'(NAME_MAX_LEN);
    localparam logic [POS_W-1:0] VALUE_LIM = POS_W'(VALUE_MAX_LEN);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    typedef enum logic [4:0] {
        ST_IDLE          = 5'd0,
        ST_MNAME         = 5'd1,
        ST_MWS           = 5'd2,
        ST_MWS1          = 5'd3,
        ST_MVALUE        = 5'd4,
        ST_REPO          = 5'd5,
        ST_REPO_WS1      = 5'd6,
        ST_REPODEF       = 5'd7,
        ST_ACL_PRE       = 5'd8,
        ST_ACL_FLAGS     = 5'd9,
        ST_ACL_WS1       = 5'd10,
        ST_REFSPEC       = 5'd11,
        ST_ACL_WS2       = 5'd12,
        ST_ACL_WS3       = 5'd13,
        ST_USERS         = 5'd14,
        ST_ACL_IGNORE    = 5'd15,
        ST_INCLUDE       = 5'd16,
        ST_INC_WS1       = 5'd17,
        ST_INC_PATH      = 5'd18,
        ST_CONFIG        = 5'd19,
        ST_CONFIG_IGNORE = 5'd20
    } t_state;

    typedef struct packed {
        t_state           st;
        logic             rd;
        logic [POS_W-1:0] pos;
        logic             emit;
        logic             fail;
        t_kind            kind;
        logic [7:0]       ch;
    } t_pst;

    t_state                r_state;
    logic                  r_read_seen;
    logic [POS_W-1:0]      r_pos;
    logic [LINE_BITS-1:0]  r_line;
    logic                  r_halted;
    logic                  r_out_valid;
    logic [3:0]            r_kind;
    logic [7:0]            r_byte;
    logic [15:0]           r_line_out;

    t_pst                  n_pst;
    logic [LINE_BITS-1:0]  n_line;
    logic                  n_halted;
    logic [LINE_BITS-1:0]  w_line_b;
    logic                  w_halted_b;
    logic                  w_res;

    function automatic t_pst f_emit(input t_pst s, input t_kind k, input logic [7:0] c);
        t_pst r;
        r      = s;
        r.emit = 1'b1;
        r.kind = k;
        r.ch   = c;
        return r;
    endfunction

    function automatic t_pst f_fail(input t_pst s, input t_kind k);
        t_pst r;
        r      = f_emit(s, k, 8'h00);
        r.fail = 1'b1;
        return r;
    endfunction

    // Byte-collecting states: terminator, length check, then emit.
    function automatic t_pst f_collect(input t_pst s, input logic term, input t_state nxt,
                                       input t_kind kend, input logic [POS_W-1:0] lim,
                                       input t_kind kbyte, input logic [7:0] c,
                                       input logic clr_pos);
        t_pst r;
        r = s;
        if (term) begin
            r.st = nxt;
            if (clr_pos) begin
                r.pos = '0;
            end
            r = f_emit(r, kend, 8'h00);
        end else if (s.pos >= lim) begin
            r = f_fail(r, K_LENGTH);
        end else begin
            r.pos = s.pos + POS_W'(1);
            r = f_emit(r, kbyte, c);
        end
        return r;
    endfunction

    function automatic t_pst f_flags(input t_pst s, input t_cls x);
        t_pst r;
        r = s;
        if (x.ch == CH_UC_R) begin
            r.rd = 1'b1;
        end else if (x.ch == CH_UC_W || x.ch == CH_PLUS || x.ch == CH_MINUS) begin
            r = s;
        end else if (x.is_eq) begin
            r.pos = '0;
            r.st  = s.rd ? ST_ACL_WS3 : ST_ACL_IGNORE;
        end else if (x.ch == CH_LC_C) begin
            r.pos = '0;
            r.st  = ST_CONFIG;
        end else if (x.ch == CH_LC_R) begin
            r.pos = '0;
            r.st  = ST_REPO;
        end else if (!x.is_ws) begin
            r = f_fail(r, K_SYNTAX);
        end else begin
            r.st  = ST_ACL_WS1;
            r.pos = '0;
        end
        return r;
    endfunction

    function automatic t_pst f_parse(input t_pst s, input t_cls x);
        t_pst             r;
        logic [POS_W-1:0] p;
        r = s;
        p = s.pos + POS_W'(1);
        case (s.st)
            ST_IDLE: begin
                r.pos = '0;
                if (x.is_at) begin
                    r.st = ST_MNAME;
                end else if (x.ch == CH_LC_R) begin
                    r.st = ST_REPO;
                end else if (x.ch == CH_LC_I) begin
                    r.st = ST_INCLUDE;
                end else if (x.ch == CH_LC_C) begin
                    r.st = ST_CONFIG;
                end
            end
            ST_MNAME: begin
                if (x.is_eq) begin
                    r.st = ST_MWS1;
                end else if (x.is_ws) begin
                    r.st = ST_MWS;
                end else if (s.pos >= NAME_LIM) begin
                    r = f_fail(r, K_LENGTH);
                end else begin
                    r.pos = p;
                    r = f_emit(r, K_MNAME, x.ch);
                end
            end
            ST_MWS: begin
                if (x.is_eq) begin
                    r.st = ST_MWS1;
                end else if (!x.is_ws) begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_MWS1: begin
                r.pos = '0;
                if (!x.is_ws) begin
                    r.st = ST_MVALUE;
                    r = f_collect(r, x.is_nl, ST_IDLE, K_MEND, VALUE_LIM, K_MVALUE, x.ch,
                                  1'b0);
                end
            end
            ST_MVALUE: begin
                r = f_collect(r, x.is_nl, ST_IDLE, K_MEND, VALUE_LIM, K_MVALUE, x.ch, 1'b0);
            end
            ST_REPO: begin
                r.pos = p;
                if ((p == POS_W'(1) && x.ch == CH_LC_E) ||
                    (p == POS_W'(2) && x.ch == CH_LC_P)) begin
                    r.st = ST_REPO;
                end else if (p == POS_W'(3) && x.ch == CH_LC_O) begin
                    r.st = ST_REPO_WS1;
                end else begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_REPO_WS1: begin
                r.pos = '0;
                if (!x.is_ws) begin
                    r.st = ST_REPODEF;
                    r = f_collect(r, x.is_nl, ST_ACL_PRE, K_REPOEND, NAME_LIM, K_REPO, x.ch,
                                  1'b1);
                end
            end
            ST_REPODEF: begin
                r = f_collect(r, x.is_nl, ST_ACL_PRE, K_REPOEND, NAME_LIM, K_REPO, x.ch, 1'b1);
            end
            ST_ACL_PRE: begin
                r.rd = 1'b0;
                if (x.is_nl) begin
                    r.st = ST_IDLE;
                end else if (!x.is_ws) begin
                    r.st = ST_ACL_FLAGS;
                    r = f_flags(r, x);
                end
            end
            ST_ACL_FLAGS: begin
                r = f_flags(r, x);
            end
            ST_ACL_WS1: begin
                r.pos = '0;
                if (x.is_eq) begin
                    r.st = s.rd ? ST_ACL_WS3 : ST_ACL_IGNORE;
                end else if (!x.is_ws) begin
                    r.st = ST_REFSPEC;
                end
            end
            ST_REFSPEC: begin
                if (x.is_ws) begin
                    r.st = ST_ACL_WS2;
                end
            end
            ST_ACL_WS2: begin
                if (x.is_eq) begin
                    r.pos = '0;
                    r.st  = s.rd ? ST_ACL_WS3 : ST_ACL_IGNORE;
                end else if (!x.is_ws) begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_ACL_WS3: begin
                if (!x.is_ws) begin
                    r.st = ST_USERS;
                    r = f_collect(r, x.is_nl, ST_ACL_PRE, K_RULEEND, VALUE_LIM, K_USER, x.ch,
                                  1'b1);
                end
            end
            ST_USERS: begin
                r = f_collect(r, x.is_nl, ST_ACL_PRE, K_RULEEND, VALUE_LIM, K_USER, x.ch, 1'b1);
            end
            ST_ACL_IGNORE: begin
                if (x.is_nl) begin
                    r.pos = '0;
                    r.st  = ST_ACL_PRE;
                end
            end
            ST_INCLUDE: begin
                r.pos = p;
                if (p >= POS_W'(1) && p <= POS_W'(6) && x.ch == f_include_char(p[2:0])) begin
                    if (p == POS_W'(6)) begin
                        r.st = ST_INC_WS1;
                    end
                end else begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_INC_WS1: begin
                r.pos = '0;
                if (x.is_quote) begin
                    r.st = ST_INC_PATH;
                end else if (!x.is_ws) begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_INC_PATH: begin
                r = f_collect(r, x.is_quote, ST_IDLE, K_INCEND, VALUE_LIM, K_INC, x.ch, 1'b0);
            end
            ST_CONFIG: begin
                r.pos = p;
                if (p >= POS_W'(1) && p <= POS_W'(5) && x.ch == f_config_char(p[2:0])) begin
                    if (p == POS_W'(5)) begin
                        r.st = ST_CONFIG_IGNORE;
                    end
                end else begin
                    r = f_fail(r, K_SYNTAX);
                end
            end
            ST_CONFIG_IGNORE: begin
                if (x.is_nl) begin
                    r.st  = ST_ACL_PRE;
                    r.pos = '0;
                    r.rd  = 1'b0;
                end
            end
            default: begin
                r.st = ST_IDLE;
            end
        endcase
        return r;
    endfunction

    assign o_item_pop = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_pst      = '0;
        n_pst.kind = K_MNAME;
        if (i_item.first) begin
            n_pst.st   = ST_IDLE;
            n_pst.rd   = 1'b0;
            n_pst.pos  = '0;
            w_line_b   = LINE_BITS'(1);
            w_halted_b = 1'b0;
        end else begin
            n_pst.st   = r_state;
            n_pst.rd   = r_read_seen;
            n_pst.pos  = r_pos;
            w_line_b   = r_line;
            w_halted_b = r_halted;
        end
        if (!w_halted_b && i_item.parse_en) begin
            n_pst = f_parse(n_pst, i_item);
        end
        n_halted = w_halted_b || n_pst.fail;
        w_res    = !w_halted_b && n_pst.emit;
        if (!w_halted_b && !n_pst.fail && i_item.is_nl && w_line_b != LINE_MAX) begin
            n_line = w_line_b + LINE_BITS'(1);
        end else begin
            n_line = w_line_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_read_seen <= 1'b0;
            r_pos       <= '0;
            r_line      <= LINE_BITS'(1);
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_state     <= n_pst.st;
                r_read_seen <= n_pst.rd;
                r_pos       <= n_pst.pos;
                r_line      <= n_line;
                r_halted    <= n_halted;
            end
            if (o_item_pop && w_res) begin
                r_out_valid <= 1'b1;
                r_kind      <= n_pst.kind;
                r_byte      <= n_pst.ch;
                r_line_out  <= 16'(w_line_b);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_byte;
    assign o_line_number = r_line_out;

endmodule

@@ hw/rtl/acl_config_text_tokenizer_core.sv @@
// Top level of the access-control configuration text tokenizer.
// Depends on acl_tok_pkg, acl_tok_front, acl_tok_queue, acl_tok_back.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_text_byte[7:0], i_first_of_file
//  out     | o_out_valid / i_out_ready | o_kind[3:0], o_out_byte[7:0], o_line_number[15:0]
//
// One byte per cycle sustained while the out channel does not stall. The front tracks
// comments and classifies the byte in the cycle it is accepted, and the byte is written
// into a two-entry queue; the back pops and parses it when the result register is free or
// being read, loading the result register, so a result passes the queue and that register.
// Bytes that give no result (comments, whitespace, keyword letters) still pass the back.
// Reset (i_rst_n low, synchronous) empties the queue and the result register and puts the
// parser in idle on line one. Stalls on the out channel hold the result register; the queue
// absorbs two bytes before o_in_ready drops. i_first_of_file restarts the parser in order
// with the byte stream.
module acl_config_text_tokenizer_core
    import acl_tok_pkg::*;
#(
    parameter int NAME_MAX_LEN  = 31,
    parameter int VALUE_MAX_LEN = 1023,
    parameter int LINE_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_first_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_line_number
);

    // front -> queue
    logic w_push;
    t_cls w_push_item;
    logic w_q_full;
    // queue -> back
    logic w_q_valid;
    t_cls w_q_item;
    logic w_pop;

    acl_tok_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_first_of_file(i_first_of_file),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    acl_tok_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_push_item),
        .o_full (w_q_full),
        .o_valid(w_q_valid),
        .o_item (w_q_item),
        .i_pop  (w_pop)
    );

    // Parser, line counter and the result register that decouples the out channel.
    acl_tok_back #(
        .NAME_MAX_LEN (NAME_MAX_LEN),
        .VALUE_MAX_LEN(VALUE_MAX_LEN),
        .LINE_BITS    (LINE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_item_pop   (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_line_number(o_line_number)
    );

endmodule

@@ hw/rtl/acl_tok_checker.sv @@
// Port-level checker for the tokenizer top level, with its bind statement.
// Depends on acl_tok_pkg and acl_config_text_tokenizer_core.
module acl_tok_checker
    import acl_tok_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_text_byte,
    input logic        i_first_of_file,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [15:0] o_line_number
);

    // A waiting input transaction holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_text_byte) &&
        $stable(i_first_of_file))
        else $error("input transaction changed while waiting");

    // A result held back by the sink stays up.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_kind) && $stable(o_out_byte) &&
        $stable(o_line_number))
        else $error("result payload changed while stalled");

    // End markers and errors carry no character.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == K_MEND || o_kind == K_REPOEND || o_kind == K_RULEEND ||
        o_kind == K_INCEND || o_kind == K_SYNTAX || o_kind == K_LENGTH) |-> o_out_byte == 8'h00)
        else $error("marker result carries a character");

    // Reset clears any pending result.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind acl_config_text_tokenizer_core acl_tok_checker u_acl_tok_checker (.*);
